// ----- rtl/skmi_pkg.sv -----
// ----------------------------------------------------------------------------
// skmi_pkg: shared types and constants of the key matrix injector
// Request codes, register indexes, controller states, command bundle and
// the character to matrix position decoder.
// ----------------------------------------------------------------------------
package skmi_pkg;

  // Text store geometry
  localparam int TEXT_DEPTH = 256;
  localparam int ADDR_W     = $clog2(TEXT_DEPTH);
  localparam int CNT_W      = $clog2(TEXT_DEPTH + 1);

  // Field widths
  localparam int REG_W  = 8;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 8;
  localparam int ROW_W  = 7;

  // Register reset values
  localparam logic [REG_W-1:0] HOLD_RESET  = 8'd4;
  localparam logic [REG_W-1:0] GAP_RESET   = 8'd4;
  localparam logic [REG_W-1:0] PAUSE_RESET = 8'd60;

  // Special characters and modifier positions
  localparam logic [CHAR_W-1:0] CHAR_TILDE = 8'h7E;
  localparam logic [CHAR_W-1:0] CHAR_AT    = 8'h40;
  localparam int                SHIFT_COL  = 7;
  localparam int                CTRL_COL   = 4;
  localparam int                MOD_ROW    = 6;
  localparam logic [ROW_W-1:0]  ROWS_IDLE  = 7'h7F;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_SCAN   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_HOLD  = 2'd0,
    CFG_GAP   = 2'd1,
    CFG_PAUSE = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic execute;  // update state, load the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] col;
    logic [2:0] row;
    logic       shift;
    logic       ctrl;
  } key_t;

  // Character to matrix position
  function automatic key_t decode_key(input logic [CHAR_W-1:0] c_in);
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] off;
    key_t k;
    c = c_in;
    if (c >= 8'h61 && c <= 8'h7A) begin
      c = c - 8'h20;
    end
    off = c - CHAR_AT;
    k.valid = 1'b1;
    k.col   = 3'd0;
    k.row   = 3'd5;
    k.shift = 1'b0;
    k.ctrl  = 1'b0;
    if (c == 8'h0D || c == 8'h0A) begin
      k.row = 3'd6;
    end else if (c == 8'h20) begin
      k.col = 3'd7;
      k.row = 3'd3;
    end else if (c >= CHAR_AT && c <= 8'h5A) begin
      k.col = off[2:0];
      k.row = off[5:3];
    end else if (c >= 8'h30 && c <= 8'h37) begin
      k.col = c[2:0];
      k.row = 3'd4;
    end else if (c == 8'h38 || c == 8'h39) begin
      k.col = {2'b00, c[0]};
    end else begin
      case (c)
        8'h3A: k.col = 3'd2;                       // :
        8'h3B: k.col = 3'd3;                       // ;
        8'h2C: k.col = 3'd4;                       // ,
        8'h2D: k.col = 3'd5;                       // -
        8'h2E: k.col = 3'd6;                       // .
        8'h2F: k.col = 3'd7;                       // /
        8'h28: begin k.col = 3'd0; k.shift = 1'b1; end  // (
        8'h29: begin k.col = 3'd1; k.shift = 1'b1; end  // )
        8'h3D: begin k.col = 3'd5; k.shift = 1'b1; end  // =
        8'h2B: begin k.col = 3'd3; k.shift = 1'b1; end  // +
        8'h2A: begin k.col = 3'd2; k.shift = 1'b1; end  // *
        8'h3F: begin k.col = 3'd7; k.shift = 1'b1; end  // ?
        8'h3C: begin k.col = 3'd4; k.shift = 1'b1; end  // <
        8'h3E: begin k.col = 3'd6; k.shift = 1'b1; end  // >
        8'h5F: begin k.col = 3'd5; k.ctrl  = 1'b1; end  // _
        8'h21: begin k.col = 3'd1; k.row = 3'd4; k.shift = 1'b1; end  // !
        8'h22: begin k.col = 3'd2; k.row = 3'd4; k.shift = 1'b1; end  // "
        8'h23: begin k.col = 3'd3; k.row = 3'd4; k.shift = 1'b1; end  // #
        8'h24: begin k.col = 3'd4; k.row = 3'd4; k.shift = 1'b1; end  // $
        8'h25: begin k.col = 3'd5; k.row = 3'd4; k.shift = 1'b1; end  // %
        8'h26: begin k.col = 3'd6; k.row = 3'd4; k.shift = 1'b1; end  // &
        8'h27: begin k.col = 3'd7; k.row = 3'd4; k.shift = 1'b1; end  // '
        default: k.valid = 1'b0;
      endcase
    end
    return k;
  endfunction

endpackage

// ----- rtl/scripted_key_matrix_injector_unit.sv -----
// ----------------------------------------------------------------------------
// scripted_key_matrix_injector_unit: types queued text into a key matrix
// Request words in on the slave stream, one result word out per request.
// ----------------------------------------------------------------------------
// Usage:
//  - s_tuser carries the request kind (clear, append, frame tick, scan);
//    s_tdata carries the character and the active-low column drive.
//  - Every request gives exactly one word on the master stream: the
//    active-low row lines, a text pending flag and an append lost flag.
//  - An accepted word executes once the text store has read the current
//    character and the output register is free, loading its result there.
//  - A new request is accepted only after the previous one has executed.
//  - Registers are written through cfg_we/cfg_index/cfg_data only while
//    idle; the user must keep to this, the block does not enforce it.
//  - If the receiver stalls, the controller holds the next request in its
//    execute step until the output register is taken; s_tready stays low.
//  - Reset empties the queue, clears the typing position and restores the
//    frame registers (hold 4, gap 4, pause 60). The text store is not
//    cleared; only entries written since the last clear are ever read.
// ----------------------------------------------------------------------------
module scripted_key_matrix_injector_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] char_code, [15:8] scan_columns
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [6:0] row_levels, [7] text_pending,
                                 // [8] append_dropped, [15:9] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import skmi_pkg::*;

  ctrl_cmd_t        cmd;
  logic [ROW_W-1:0] row_levels;
  logic             text_pending;
  logic             append_dropped;

  skmi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  skmi_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .req_in         (s_tuser),
    .char_in        (s_tdata[7:0]),
    .cols_in        (s_tdata[15:8]),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .row_levels     (row_levels),
    .text_pending   (text_pending),
    .append_dropped (append_dropped)
  );

  assign m_tdata = {7'b0, append_dropped, text_pending, row_levels};

  // Assertions
  a_no_accept_in_exec: assert property (@(posedge clk) disable iff (rst)
    !(cmd.execute && s_tvalid && s_tready))
    else $error("word accepted while a request executes");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted before execution");

  a_exec_gives_word: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> m_tvalid)
    else $error("executed request produced no output word");

  a_drop_no_rows: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8]) |-> (m_tdata[6:0] == ROWS_IDLE))
    else $error("dropped append carries pressed rows");

endmodule

// ----- rtl/skmi_ctrl.sv -----
// ----------------------------------------------------------------------------
// skmi_ctrl: request sequencer
// Accepts one word, waits for the text store read, then executes it into
// the output register once that register is free.
// ----------------------------------------------------------------------------
module skmi_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output skmi_pkg::ctrl_cmd_t cmd
);
  import skmi_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_free;

  assign out_free = !out_valid || m_tready;

  // State register and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      ST_EXEC: cmd.execute = out_free;
      default: ;
    endcase
  end

  assign m_tvalid = out_valid;

endmodule

// ----- rtl/skmi_dpath.sv -----
// ----------------------------------------------------------------------------
// skmi_dpath: text store, typing position, frame phase and row generation
// Holds the configuration registers and the output word register.
// ----------------------------------------------------------------------------
module skmi_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  skmi_pkg::ctrl_cmd_t         cmd,
  input  logic [1:0]                  req_in,
  input  logic [skmi_pkg::CHAR_W-1:0] char_in,
  input  logic [skmi_pkg::COL_W-1:0]  cols_in,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [skmi_pkg::REG_W-1:0]  cfg_data,
  output logic [skmi_pkg::ROW_W-1:0]  row_levels,
  output logic                        text_pending,
  output logic                        append_dropped
);
  import skmi_pkg::*;

  logic [CHAR_W-1:0] text_store [TEXT_DEPTH];
  logic [CHAR_W-1:0] cur_char;

  logic [REG_W-1:0]  hold_frames;
  logic [REG_W-1:0]  gap_frames;
  logic [REG_W-1:0]  pause_frames;

  req_t              req;
  logic [CHAR_W-1:0] char_q;
  logic [COL_W-1:0]  cols_q;

  logic [CNT_W-1:0]  char_count;
  logic [CNT_W-1:0]  char_count_next;
  logic [CNT_W-1:0]  read_position;
  logic [CNT_W-1:0]  read_position_next;
  logic [REG_W-1:0]  frame_phase;
  logic [REG_W-1:0]  frame_phase_next;

  logic              pending;
  logic              full;
  logic              store_wr;
  logic [REG_W:0]    frames;
  logic [REG_W:0]    phase_inc;
  logic [COL_W-1:0]  active;
  logic [ROW_W-1:0]  rows;
  logic [ROW_W-1:0]  rows_out;
  logic              dropped;
  key_t              key;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_frames  <= HOLD_RESET;
      gap_frames   <= GAP_RESET;
      pause_frames <= PAUSE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HOLD:  hold_frames  <= cfg_data;
        CFG_GAP:   gap_frames   <= cfg_data;
        CFG_PAUSE: pause_frames <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req    <= req_t'(req_in);
      char_q <= char_in;
      cols_q <= cols_in;
    end
  end

  // Text store: registered read of the current character, write on append
  always_ff @(posedge clk) begin
    cur_char <= text_store[read_position[ADDR_W-1:0]];
    if (store_wr) begin
      text_store[char_count[ADDR_W-1:0]] <= char_q;
    end
  end

  assign pending  = read_position < char_count;
  assign full     = char_count == CNT_W'(TEXT_DEPTH);
  assign store_wr = cmd.execute && req == REQ_APPEND && !full;

  // Frame length of the current character
  assign frames    = (cur_char == CHAR_TILDE) ? {1'b0, pause_frames}
                                              : {1'b0, hold_frames} + {1'b0, gap_frames};
  assign phase_inc = {1'b0, frame_phase} + 1'b1;

  // Row lines for a scan
  assign key    = decode_key(cur_char);
  assign active = ~cols_q;
  always_comb begin
    rows = '0;
    if (pending && frame_phase < hold_frames && key.valid) begin
      if (active[key.col]) begin
        rows = ROW_W'(1) << key.row;
      end
      if ((key.shift && active[SHIFT_COL]) || (key.ctrl && active[CTRL_COL])) begin
        rows[MOD_ROW] = 1'b1;
      end
    end
  end

  // Next state for the executed request
  always_comb begin
    char_count_next    = char_count;
    read_position_next = read_position;
    frame_phase_next   = frame_phase;
    rows_out           = ROWS_IDLE;
    dropped            = 1'b0;
    case (req)
      REQ_CLEAR: begin
        char_count_next    = '0;
        read_position_next = '0;
        frame_phase_next   = '0;
      end
      REQ_APPEND: begin
        if (full) dropped = 1'b1;
        else      char_count_next = char_count + 1'b1;
      end
      REQ_TICK: begin
        if (pending) begin
          if (phase_inc >= frames || phase_inc[REG_W]) begin
            frame_phase_next   = '0;
            read_position_next = read_position + 1'b1;
          end else begin
            frame_phase_next = phase_inc[REG_W-1:0];
          end
        end
      end
      REQ_SCAN: rows_out = ~rows;
      default: ;
    endcase
  end

  // Typing state
  always_ff @(posedge clk) begin
    if (rst) begin
      char_count    <= '0;
      read_position <= '0;
      frame_phase   <= '0;
    end else if (cmd.execute) begin
      char_count    <= char_count_next;
      read_position <= read_position_next;
      frame_phase   <= frame_phase_next;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      row_levels     <= rows_out;
      text_pending   <= read_position_next < char_count_next;
      append_dropped <= dropped;
    end
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for scripted_key_matrix_injector_unit
// Drives clear, append, frame tick and column scan words on the request
// stream and checks every result word against a typing model kept in the
// bench, across several hold, gap and pause settings. Both streams idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import skmi_pkg::*;

  // One result word: active-low rows, text pending flag, append lost flag
  typedef struct packed {
    logic [ROW_W-1:0] rows;
    logic             pending;
    logic             dropped;
  } scan_word_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;  // [7:0] char_code, [15:8] scan_columns
  logic [1:0]  s_tuser   = REQ_CLEAR;  // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;   // [6:0] row_levels, [7] text_pending, [8] append_dropped
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_HOLD;
  logic [7:0]  cfg_data  = '0;

  // Typing model state
  logic [CHAR_W-1:0] text_mem [TEXT_DEPTH];
  int unsigned       stored_chars;
  int unsigned       typing_pos;
  logic [7:0]        frame_cnt;
  logic [REG_W-1:0]  hold_len;
  logic [REG_W-1:0]  gap_len;
  logic [REG_W-1:0]  pause_len;

  scan_word_t awaited_words [$];
  scan_word_t due_word;
  int         fail_count = 0;
  int         idle_pct   = 7;

  string key_chars = "@AZQM0179:;,-./()=+*?<>_!\"#$%&' \015\n[\\]^{|}`azq";

  scripted_key_matrix_injector_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Receiver: random stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= idle_pct);
  end

  // --------------------------------------------------------------------------
  // Typing model
  // --------------------------------------------------------------------------

  // Matrix position of a character; returns 0 when no key is mapped
  function automatic logic key_position(input logic [7:0] code, output logic [2:0] col,
                                        output logic [2:0] row, output logic shifted,
                                        output logic with_ctrl);
    logic [7:0] c;
    logic [7:0] rel;
    c         = code;
    col       = 3'd0;
    row       = 3'd5;
    shifted   = 1'b0;
    with_ctrl = 1'b0;
    key_position = 1'b1;
    if (c >= "a" && c <= "z") begin
      c = c - 8'd32;
    end
    rel = c - CHAR_AT;
    if (c == 8'h0D || c == 8'h0A) begin
      row = 3'd6;
    end else if (c == " ") begin
      col = 3'd7;
      row = 3'd3;
    end else if (c >= CHAR_AT && c <= "Z") begin
      col = rel[2:0];
      row = rel[5:3];
    end else if (c >= "0" && c <= "9") begin
      rel = c - "0";
      col = rel[2:0];
      row = (rel < 8) ? 3'd4 : 3'd5;
    end else begin
      case (c)
        ":":  col = 3'd2;
        ";":  col = 3'd3;
        ",":  col = 3'd4;
        "-":  col = 3'd5;
        ".":  col = 3'd6;
        "/":  col = 3'd7;
        "(":  begin col = 3'd0; shifted = 1'b1; end
        ")":  begin col = 3'd1; shifted = 1'b1; end
        "*":  begin col = 3'd2; shifted = 1'b1; end
        "+":  begin col = 3'd3; shifted = 1'b1; end
        "<":  begin col = 3'd4; shifted = 1'b1; end
        "=":  begin col = 3'd5; shifted = 1'b1; end
        ">":  begin col = 3'd6; shifted = 1'b1; end
        "?":  begin col = 3'd7; shifted = 1'b1; end
        "_":  begin col = 3'd5; with_ctrl = 1'b1; end
        "!":  begin col = 3'd1; row = 3'd4; shifted = 1'b1; end
        "\"": begin col = 3'd2; row = 3'd4; shifted = 1'b1; end
        "#":  begin col = 3'd3; row = 3'd4; shifted = 1'b1; end
        "$":  begin col = 3'd4; row = 3'd4; shifted = 1'b1; end
        "%":  begin col = 3'd5; row = 3'd4; shifted = 1'b1; end
        "&":  begin col = 3'd6; row = 3'd4; shifted = 1'b1; end
        "'":  begin col = 3'd7; row = 3'd4; shifted = 1'b1; end
        default: key_position = 1'b0;
      endcase
    end
  endfunction

  // Rows pulled low by the current character for a given column drive
  function automatic logic [ROW_W-1:0] scanned_rows(input logic [7:0] drive);
    logic [2:0]       col;
    logic [2:0]       row;
    logic             sh;
    logic             ct;
    logic             mapped;
    logic [7:0]       act;
    logic [ROW_W-1:0] low;
    low = '0;
    act = ~drive;
    if (typing_pos < stored_chars && frame_cnt < hold_len) begin
      mapped = key_position(text_mem[typing_pos], col, row, sh, ct);
      if (mapped) begin
        if (act[col]) low[row] = 1'b1;
        if (sh && act[SHIFT_COL]) low[MOD_ROW] = 1'b1;
        if (ct && act[CTRL_COL]) low[MOD_ROW] = 1'b1;
      end
    end
    return ~low;
  endfunction

  // One frame on the current character; phase counter wraps at 256 frames
  task automatic frame_advance;
    int unsigned span;
    int unsigned nxt;
    if (typing_pos < stored_chars) begin
      if (text_mem[typing_pos] == CHAR_TILDE) span = int'(pause_len);
      else span = int'(hold_len) + int'(gap_len);
      nxt = int'(frame_cnt) + 1;
      if (nxt >= span || nxt >= 256) begin
        frame_cnt = '0;
        typing_pos++;
      end else begin
        frame_cnt = nxt[7:0];
      end
    end
  endtask

  // Apply one accepted request to the model and queue its result word
  task automatic typist_step(input req_t kind, input logic [7:0] ch, input logic [7:0] cols);
    scan_word_t w;
    w.rows    = ROWS_IDLE;
    w.dropped = 1'b0;
    case (kind)
      REQ_CLEAR: begin
        stored_chars = 0;
        typing_pos   = 0;
        frame_cnt    = '0;
      end
      REQ_APPEND: begin
        if (stored_chars < TEXT_DEPTH) begin
          text_mem[stored_chars] = ch;
          stored_chars++;
        end else begin
          w.dropped = 1'b1;
        end
      end
      REQ_TICK: frame_advance();
      REQ_SCAN: w.rows = scanned_rows(cols);
      default: ;
    endcase
    w.pending = (typing_pos < stored_chars);
    awaited_words.push_back(w);
  endtask

  // --------------------------------------------------------------------------
  // Stream and register drivers
  // --------------------------------------------------------------------------

  // Send one request word; tvalid stays high between back-to-back words
  task automatic send_req(input req_t kind, input logic [7:0] ch, input logic [7:0] cols);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {cols, ch};
    do @(posedge clk); while (!s_tready);
    typist_step(kind, ch, cols);
  endtask

  task automatic append_char(input logic [7:0] ch);
    send_req(REQ_APPEND, ch, 8'($urandom));
  endtask

  task automatic tick;
    send_req(REQ_TICK, 8'($urandom), 8'($urandom));
  endtask

  task automatic scan(input logic [7:0] cols);
    send_req(REQ_SCAN, 8'($urandom), cols);
  endtask

  task automatic clear_text;
    send_req(REQ_CLEAR, 8'($urandom), 8'($urandom));
  endtask

  // Wait until every result is in and the block has settled
  task automatic drain_results;
    s_tvalid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frames(input logic [7:0] h, input logic [7:0] g, input logic [7:0] p);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HOLD;
    cfg_data  <= h;
    @(posedge clk);
    hold_len  = h;
    cfg_index <= CFG_GAP;
    cfg_data  <= g;
    @(posedge clk);
    gap_len   = g;
    cfg_index <= CFG_PAUSE;
    cfg_data  <= p;
    @(posedge clk);
    pause_len = p;
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 65) return key_chars[$urandom_range(key_chars.len() - 1)];
    if (r < 75) return CHAR_TILDE;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_columns();
    int r;
    r = $urandom_range(99);
    if (r < 45) return ~(8'h01 << $urandom_range(7));
    if (r < 60) return 8'h00;
    if (r < 68) return 8'hFF;
    if (r < 78) return ~(8'h01 << $urandom_range(7)) & 8'h6F;
    return 8'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_words.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result word %h", m_tdata);
      end else begin
        due_word = awaited_words.pop_front();
        if (m_tdata[6:0] != due_word.rows || m_tdata[7] != due_word.pending ||
            m_tdata[8] != due_word.dropped || m_tdata[15:9] != '0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: rows %h/%h pending %b/%b dropped %b/%b pad %h (exp/got)",
                     due_word.rows, m_tdata[6:0], due_word.pending, m_tdata[7],
                     due_word.dropped, m_tdata[8], m_tdata[15:9]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset frame settings: one key held, released, modifiers, odd codes
  task automatic test_directed;
    scan(8'h00);                 // empty queue
    tick();
    append_char("a");            // folds to A, col 1 row 0
    scan(8'hFE);
    scan(8'hFD);
    repeat (3) tick();
    scan(8'h00);                 // last held frame
    tick();
    scan(8'h00);                 // now in the gap
    append_char("_");
    append_char("!");
    append_char(8'h80);
    append_char(8'hFF);
    append_char(CHAR_TILDE);
    repeat (4) tick();           // A done, underscore current
    scan(8'hDF);                 // base key only
    scan(8'hEF);                 // CTRL column only
    clear_text();
    scan(8'h00);
    append_char("x");
    tick();
  endtask

  // Key map characters and unmapped codes, all columns or only SHIFT and CTRL driven
  task automatic test_key_map;
    int i;
    write_frames(8'd1, 8'd0, 8'd1);
    clear_text();
    for (i = 0; i < key_chars.len(); i++) append_char(key_chars[i]);
    append_char(8'h00);
    append_char(8'h7F);
    append_char(8'h80);
    append_char(8'hFF);
    for (i = 0; i < key_chars.len() + 4; i++) begin
      scan(8'h00);
      scan(8'h6F);
      tick();
    end
  endtask

  // Fill the store, lose appends, type it all, still full until a clear;
  // run with no idling on either side
  task automatic test_full_store;
    int i;
    write_frames(8'd1, 8'd0, 8'd1);
    idle_pct = 0;
    clear_text();
    for (i = 0; i < TEXT_DEPTH; i++) append_char(8'($urandom));
    repeat (3) append_char(pick_char());
    for (i = 0; i < TEXT_DEPTH; i++) begin
      if (i % 64 == 0) scan(pick_columns());
      tick();
    end
    tick();
    append_char("K");
    scan(8'h00);
    clear_text();
    append_char("K");
    scan(8'h00);
    idle_pct = 7;
  endtask

  // Zero-length characters and the longest ones
  task automatic test_frame_extremes;
    int i;
    write_frames(8'd0, 8'd0, 8'd1);
    clear_text();
    append_char("A");
    append_char(CHAR_TILDE);
    append_char("B");
    scan(8'h00);
    repeat (3) tick();
    tick();
    append_char("C");            // typing resumes after the text is done
    scan(8'h00);
    tick();

    write_frames(8'd255, 8'd255, 8'd255);
    clear_text();
    append_char("Q");
    scan(8'h00);
    for (i = 0; i < 254; i++) tick();
    scan(8'h00);                 // phase 254, still held
    tick();
    scan(8'h00);                 // phase 255, released
    tick();                      // ends after 256 frames
    scan(8'h00);
    append_char("Z");
    scan(8'h00);
  endtask

  // Random request mix over a few frame settings
  task automatic test_random_typing;
    logic [7:0] holds  [4] = '{8'd2, 8'd1, 8'd3, 8'd6};
    logic [7:0] gaps   [4] = '{8'd1, 8'd0, 8'd2, 8'd0};
    logic [7:0] pauses [4] = '{8'd3, 8'd1, 8'd5, 8'd4};
    int s;
    int n;
    int r;
    for (s = 0; s < 4; s++) begin
      write_frames(holds[s], gaps[s], pauses[s]);
      for (n = 0; n < 20; n++) begin
        r = $urandom_range(99);
        if (r < 2) clear_text();
        else if (r < 30) append_char(pick_char());
        else if (r < 65) tick();
        else scan(pick_columns());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stored_chars = 0;
    typing_pos   = 0;
    frame_cnt    = '0;
    hold_len     = HOLD_RESET;
    gap_len      = GAP_RESET;
    pause_len    = PAUSE_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_key_map();
    test_full_store();
    test_frame_extremes();
    test_random_typing();
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && awaited_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
